/* src/usb_config_descriptor_walker_macros.svh */
// assertion macros for the usb configuration descriptor walker
// needs clk_i and rst_ni in the scope of the module that uses them
`ifndef USB_CONFIG_DESCRIPTOR_WALKER_MACROS_SVH
`define USB_CONFIG_DESCRIPTOR_WALKER_MACROS_SVH

// same-cycle implication
`define UCDW_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ucdw assertion failed");

// next-cycle implication
`define UCDW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ucdw assertion failed");

`endif

/* src/ucdw_pkg.sv */
// shared types and constants for the usb configuration descriptor walker
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ucdw_pkg;

  // slot limits and defaults
  localparam int unsigned IF_SLOTS_DEF = 4;
  localparam int unsigned EP_SLOTS_DEF = 4;
  localparam int unsigned SLOTS_MAX    = 16;
  localparam int unsigned CNT_W        = $clog2(SLOTS_MAX + 1);

  // queue depths
  localparam int unsigned MID_DEPTH = 4;
  localparam int unsigned RES_DEPTH = 4;

  // descriptor type codes
  localparam logic [7:0] TYPE_INTERFACE = 8'h04;
  localparam logic [7:0] TYPE_ENDPOINT  = 8'h05;
  localparam logic [7:0] TYPE_HID       = 8'h21;
  localparam logic [7:0] TYPE_REPORT    = 8'h22;
  localparam logic [7:0] ADDR_MASK      = 8'h7f;
  localparam logic [7:0] DIR_IN_BIT     = 8'h80;

  typedef enum logic [1:0] {
    REC_INTERFACE = 2'd0,
    REC_REPORT    = 2'd1,
    REC_ENDPOINT  = 2'd2,
    REC_DONE      = 2'd3
  } record_kind_e;

  typedef enum logic [1:0] {
    STOP_RUN      = 2'd0,
    STOP_BAD_IF   = 2'd1,
    STOP_ZERO_LEN = 2'd2,
    STOP_ENDED    = 2'd3
  } stop_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_IF   = 2'd1,
    STATUS_ZERO_LEN = 2'd2
  } walk_status_e;

  // classified byte from the front part
  typedef struct packed {
    logic [7:0]       data;
    logic             last;
    logic             pos_is1;
    logic             past_limit;
    logic [CNT_W-1:0] clamped;
  } byte_item_t;

  // one output record as it appears on the ports
  typedef struct packed {
    record_kind_e kind;
    logic [1:0]   if_num;
    logic [7:0]   if_class;
    logic [7:0]   if_subclass;
    logic [7:0]   if_protocol;
    logic [1:0]   ep_slot;
    logic [6:0]   ep_addr;
    logic         ep_in;
    logic [15:0]  length;
    logic [2:0]   if_count;
    walk_status_e status;
    logic         last;
  } record_t;

  // everything one byte produces: a walk record and/or a done record
  typedef struct packed {
    logic         walk_valid;
    record_t      walk_rec;
    logic         done_valid;
    logic [2:0]   if_count;
    walk_status_e status;
  } result_t;

endpackage

`default_nettype wire

/* src/ucdw_fifo.sv */
// small register queue used between the walker parts
// depends on the assertion macros
`timescale 1ns / 1ps
`default_nettype none

`include "usb_config_descriptor_walker_macros.svh"

module ucdw_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  // handshake
  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `UCDW_ASSERT_IMPL(a_fifo_cnt_range, 1'b1, cnt_q <= CntW'(DEPTH))

endmodule

`default_nettype wire

/* src/ucdw_front.sv */
// front part: takes bytes, tracks stream position and header fields
// depends on ucdw_pkg
`timescale 1ns / 1ps
`default_nettype none

module ucdw_front #(
  parameter int unsigned INTERFACE_SLOTS = ucdw_pkg::IF_SLOTS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire logic [7:0]         data_byte_i,
  input  wire logic               last_byte_i,
  input  wire logic               full_i,
  output logic                    item_push_o,
  output ucdw_pkg::byte_item_t    item_o
);

  import ucdw_pkg::*;

  logic [15:0]      pos_q, pos_d;
  logic [15:0]      limit_q, limit_d;
  logic [CNT_W-1:0] clamped_q, clamped_d;
  logic             take;

  assign take        = push_i && !full_i;
  assign item_push_o = take;

  // header capture from stream bytes two to four
  always_comb begin
    limit_d   = limit_q;
    clamped_d = clamped_q;
    if (pos_q == 16'd2) begin
      limit_d = {limit_q[15:8], data_byte_i};
    end else if (pos_q == 16'd3) begin
      limit_d = {data_byte_i, limit_q[7:0]};
    end else if (pos_q == 16'd4) begin
      clamped_d = (data_byte_i > 8'(INTERFACE_SLOTS)) ? CNT_W'(INTERFACE_SLOTS)
                                                     : CNT_W'(data_byte_i);
    end
    pos_d = (pos_q == 16'hffff) ? pos_q : pos_q + 16'd1;
  end

  // classified item
  always_comb begin
    item_o.data       = data_byte_i;
    item_o.last       = last_byte_i;
    item_o.pos_is1    = (pos_q == 16'd1);
    item_o.past_limit = (pos_q != 16'd0) && (pos_q >= limit_d);
    item_o.clamped    = clamped_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      limit_q   <= '0;
      clamped_q <= '0;
    end else if (take) begin
      if (last_byte_i) begin
        pos_q     <= '0;
        limit_q   <= '0;
        clamped_q <= '0;
      end else begin
        pos_q     <= pos_d;
        limit_q   <= limit_d;
        clamped_q <= clamped_d;
      end
    end
  end

endmodule

`default_nettype wire

/* src/ucdw_walk.sv */
// back part: descriptor walk over classified bytes, builds records
// depends on ucdw_pkg and the assertion macros
`timescale 1ns / 1ps
`default_nettype none

`include "usb_config_descriptor_walker_macros.svh"

module ucdw_walk #(
  parameter int unsigned INTERFACE_SLOTS = ucdw_pkg::IF_SLOTS_DEF,
  parameter int unsigned ENDPOINT_SLOTS  = ucdw_pkg::EP_SLOTS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ucdw_pkg::byte_item_t item_i,
  input  wire logic               item_valid_i,
  output logic                    item_pop_o,
  input  wire logic               out_full_i,
  output logic                    res_push_o,
  output ucdw_pkg::result_t       res_o
);

  import ucdw_pkg::*;

  localparam int unsigned IdxW = (INTERFACE_SLOTS > 1) ? $clog2(INTERFACE_SLOTS) : 1;

  logic [7:0]       bid_q, bid_d;
  logic [7:0]       dlen_q, dlen_d;
  logic [7:0]       dtype_q, dtype_d;
  logic [7:0]       lo_q, lo_d, hi_q, hi_d;
  logic             acc_q, acc_d;
  logic [IdxW-1:0]  cur_q, cur_d;
  logic             alt_q, alt_d;
  logic             seen_q, seen_d;
  stop_e            stop_q, stop_d;
  logic [CNT_W-1:0] counts_q [INTERFACE_SLOTS];

  logic             take;
  logic [7:0]       b;
  logic [7:0]       len_new;
  logic [8:0]       off_inc;
  logic             go;
  logic [CNT_W-1:0] ep_cnt;
  logic             cnt_we;
  logic [CNT_W-1:0] cnt_wval;
  logic [7:0]       cur_ext;
  logic [7:0]       clamp_ext;
  logic             rec_valid;
  record_t          rec;

  assign take       = item_valid_i && !out_full_i;
  assign item_pop_o = take;
  assign b          = item_i.data;
  assign ep_cnt     = counts_q[cur_q];
  assign cur_ext    = 8'(cur_q);
  assign clamp_ext  = 8'(item_i.clamped);

  // walk step
  always_comb begin
    bid_d     = bid_q;
    dlen_d    = dlen_q;
    dtype_d   = dtype_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    acc_d     = acc_q;
    cur_d     = cur_q;
    alt_d     = alt_q;
    seen_d    = seen_q;
    stop_d    = stop_q;
    cnt_we    = 1'b0;
    cnt_wval  = '0;
    go        = 1'b0;
    len_new   = dlen_q;
    off_inc   = {1'b0, bid_q} + 9'd1;
    rec_valid = 1'b0;
    rec       = '0;
    rec.if_num = cur_ext[1:0];

    if (stop_q == STOP_RUN) begin
      go = 1'b1;
      if (bid_q == 8'd0) begin
        // descriptor start
        if (item_i.past_limit) begin
          stop_d = STOP_ENDED;
          go     = 1'b0;
        end else if (b == 8'd0) begin
          stop_d = STOP_ZERO_LEN;
          go     = 1'b0;
        end else begin
          dlen_d  = b;
          len_new = b;
          dtype_d = '0;
          lo_d    = '0;
          hi_d    = '0;
          acc_d   = 1'b0;
        end
      end else if (bid_q == 8'd1) begin
        if (!item_i.pos_is1) begin
          dtype_d = b;
        end
      end else if (dtype_q == TYPE_INTERFACE) begin
        unique case (bid_q)
          8'd2: begin
            if (b >= clamp_ext) begin
              stop_d = STOP_BAD_IF;
              go     = 1'b0;
            end else begin
              cur_d  = IdxW'(b);
              seen_d = 1'b1;
            end
          end
          8'd3: begin
            alt_d = (b == 8'd0);
            if (b == 8'd0) begin
              cnt_we = 1'b1;
            end
          end
          8'd5: lo_d = b;
          8'd6: hi_d = b;
          8'd7: begin
            if (alt_q) begin
              rec_valid       = 1'b1;
              rec.kind        = REC_INTERFACE;
              rec.if_class    = lo_q;
              rec.if_subclass = hi_q;
              rec.if_protocol = b;
            end
          end
          default: ;
        endcase
      end else if (dtype_q == TYPE_HID) begin
        unique case (bid_q)
          8'd6: lo_d = b;
          8'd7: hi_d = b;
          8'd8: begin
            if (seen_q && lo_q == TYPE_REPORT) begin
              rec_valid  = 1'b1;
              rec.kind   = REC_REPORT;
              rec.length = {b, hi_q};
            end
          end
          default: ;
        endcase
      end else if (dtype_q == TYPE_ENDPOINT) begin
        unique case (bid_q)
          8'd2: begin
            if (seen_q && alt_q && ep_cnt < CNT_W'(ENDPOINT_SLOTS)) begin
              acc_d = 1'b1;
              lo_d  = b;
              hi_d  = '0;
            end
          end
          8'd4: hi_d = b;
          8'd5: begin
            if (acc_q) begin
              rec_valid   = 1'b1;
              rec.kind    = REC_ENDPOINT;
              rec.ep_slot = ep_cnt[1:0];
              rec.ep_addr = 7'(lo_q & ADDR_MASK);
              rec.ep_in   = |(lo_q & DIR_IN_BIT);
              rec.length  = {b, hi_q};
              cnt_we      = 1'b1;
              cnt_wval    = ep_cnt + 1'b1;
              acc_d       = 1'b0;
            end
          end
          default: ;
        endcase
      end

      // advance within the descriptor
      if (go) begin
        bid_d = (off_inc >= {1'b0, len_new}) ? 8'd0 : off_inc[7:0];
      end
    end
  end

  // result for the output queue
  always_comb begin
    res_o.walk_valid = rec_valid;
    res_o.walk_rec   = rec;
    res_o.done_valid = item_i.last;
    res_o.if_count   = clamp_ext[2:0];
    case (stop_d)
      STOP_BAD_IF:   res_o.status = STATUS_BAD_IF;
      STOP_ZERO_LEN: res_o.status = STATUS_ZERO_LEN;
      default:       res_o.status = STATUS_OK;
    endcase
  end

  assign res_push_o = take && (rec_valid || item_i.last);

  // walk state, cleared after each last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bid_q   <= '0;
      dlen_q  <= '0;
      dtype_q <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      acc_q   <= 1'b0;
      cur_q   <= '0;
      alt_q   <= 1'b0;
      seen_q  <= 1'b0;
      stop_q  <= STOP_RUN;
      for (int i = 0; i < INTERFACE_SLOTS; i++) begin
        counts_q[i] <= '0;
      end
    end else if (take) begin
      if (item_i.last) begin
        bid_q   <= '0;
        dlen_q  <= '0;
        dtype_q <= '0;
        lo_q    <= '0;
        hi_q    <= '0;
        acc_q   <= 1'b0;
        cur_q   <= '0;
        alt_q   <= 1'b0;
        seen_q  <= 1'b0;
        stop_q  <= STOP_RUN;
        for (int i = 0; i < INTERFACE_SLOTS; i++) begin
          counts_q[i] <= '0;
        end
      end else begin
        bid_q   <= bid_d;
        dlen_q  <= dlen_d;
        dtype_q <= dtype_d;
        lo_q    <= lo_d;
        hi_q    <= hi_d;
        acc_q   <= acc_d;
        cur_q   <= cur_d;
        alt_q   <= alt_d;
        seen_q  <= seen_d;
        stop_q  <= stop_d;
        if (cnt_we) begin
          counts_q[cur_q] <= cnt_wval;
        end
      end
    end
  end

  `UCDW_ASSERT_NEXT(a_walk_clears, take && item_i.last, stop_q == STOP_RUN && bid_q == 8'd0)
  `UCDW_ASSERT_IMPL(a_no_rec_stopped, stop_q != STOP_RUN, !rec_valid)

endmodule

`default_nettype wire

/* src/ucdw_emit.sv */
// result queue and record sequencer: walk record first, then done record
// depends on ucdw_pkg, ucdw_fifo and the assertion macros
`timescale 1ns / 1ps
`default_nettype none

`include "usb_config_descriptor_walker_macros.svh"

module ucdw_emit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              res_push_i,
  input  wire ucdw_pkg::result_t res_i,
  output logic                   res_full_o,
  input  wire logic              pop_i,
  output logic                   empty_o,
  output ucdw_pkg::record_t      rec_o
);

  import ucdw_pkg::*;

  logic [$bits(result_t)-1:0] head_raw;
  result_t                    head;
  logic                       fifo_empty;
  logic                       fifo_pop;
  logic                       show_done;
  logic                       phase_q, phase_d;
  logic                       take;

  ucdw_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push_i),
    .data_i  (res_i),
    .full_o  (res_full_o),
    .pop_i   (fifo_pop),
    .data_o  (head_raw),
    .empty_o (fifo_empty)
  );

  assign head      = result_t'(head_raw);
  assign empty_o   = fifo_empty;
  assign take      = pop_i && !fifo_empty;
  assign show_done = !head.walk_valid || phase_q;
  assign fifo_pop  = take && (show_done || !head.done_valid);

  // pick the record on view
  always_comb begin
    if (show_done) begin
      rec_o          = '0;
      rec_o.kind     = REC_DONE;
      rec_o.if_count = head.if_count;
      rec_o.status   = head.status;
      rec_o.last     = 1'b1;
    end else begin
      rec_o = head.walk_rec;
    end
  end

  // phase: walk record of a two-record entry already taken
  always_comb begin
    phase_d = phase_q;
    if (take) begin
      phase_d = !fifo_pop;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
    end
  end

  `UCDW_ASSERT_IMPL(a_phase_pair, phase_q, !fifo_empty && head.walk_valid && head.done_valid)

endmodule

`default_nettype wire

/* src/usb_config_descriptor_walker.sv */
// top level of the usb configuration descriptor walker
// depends on ucdw_pkg, ucdw_fifo, ucdw_front, ucdw_walk and ucdw_emit
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+------------------------------------------
//  bytes    | in        | push / full         | data_byte_i, last_byte_i
//  records  | out       | empty / pop         | record_kind_o .. last_record_o
//
// one byte is taken per cycle while full is low; its records pass the byte queue, then the result queue
// one record leaves per cycle while empty is low; a last byte that also ends a record gives two records
// the walk engine stalls only while the result queue is full, the byte queue absorbs that
// reset is asynchronous, active low, and leaves both queues empty with no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module usb_config_descriptor_walker #(
  parameter int unsigned INTERFACE_SLOTS = ucdw_pkg::IF_SLOTS_DEF,
  parameter int unsigned ENDPOINT_SLOTS  = ucdw_pkg::EP_SLOTS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             full,
  input  wire logic        pop,
  output logic             empty,
  output logic [1:0]       record_kind_o,
  output logic [1:0]       interface_number_o,
  output logic [7:0]       interface_class_o,
  output logic [7:0]       interface_subclass_o,
  output logic [7:0]       interface_protocol_o,
  output logic [1:0]       endpoint_slot_o,
  output logic [6:0]       endpoint_address_o,
  output logic             endpoint_is_in_o,
  output logic [15:0]      length_value_o,
  output logic [2:0]       interface_count_o,
  output logic [1:0]       walk_status_o,
  output logic             last_record_o
);

  import ucdw_pkg::*;

  byte_item_t                    front_item;
  logic                          front_push;
  logic [$bits(byte_item_t)-1:0] mid_raw;
  logic                          mid_empty;
  logic                          mid_pop;
  result_t                       res;
  logic                          res_push;
  logic                          res_full;
  record_t                       rec;

  // front: byte intake and header tracking
  ucdw_front #(
    .INTERFACE_SLOTS (INTERFACE_SLOTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .full_i      (full),
    .item_push_o (front_push),
    .item_o      (front_item)
  );

  // queue between front and walk engine
  ucdw_fifo #(
    .WIDTH ($bits(byte_item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (front_item),
    .full_o  (full),
    .pop_i   (mid_pop),
    .data_o  (mid_raw),
    .empty_o (mid_empty)
  );

  // walk engine
  ucdw_walk #(
    .INTERFACE_SLOTS (INTERFACE_SLOTS),
    .ENDPOINT_SLOTS  (ENDPOINT_SLOTS)
  ) u_walk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (byte_item_t'(mid_raw)),
    .item_valid_i (!mid_empty),
    .item_pop_o   (mid_pop),
    .out_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res)
  );

  // result queue and record sequencing
  ucdw_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_push_i (res_push),
    .res_i      (res),
    .res_full_o (res_full),
    .pop_i      (pop),
    .empty_o    (empty),
    .rec_o      (rec)
  );

  // result ports
  assign record_kind_o        = rec.kind;
  assign interface_number_o   = rec.if_num;
  assign interface_class_o    = rec.if_class;
  assign interface_subclass_o = rec.if_subclass;
  assign interface_protocol_o = rec.if_protocol;
  assign endpoint_slot_o      = rec.ep_slot;
  assign endpoint_address_o   = rec.ep_addr;
  assign endpoint_is_in_o     = rec.ep_in;
  assign length_value_o       = rec.length;
  assign interface_count_o    = rec.if_count;
  assign walk_status_o        = rec.status;
  assign last_record_o        = rec.last;

endmodule

`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps
// testbench for usb_config_descriptor_walker: feeds descriptor bytes as requests and checks
// each returned record against a behavioural predictor; depends on ucdw_pkg and the walker rtl

module tb;
  import ucdw_pkg::*;

  localparam int unsigned IF_SLOTS     = IF_SLOTS_DEF;
  localparam int unsigned EP_SLOTS     = EP_SLOTS_DEF;
  localparam int unsigned ACCEPT_BIT   = 23;
  localparam logic [7:0]  TYPE_CONFIG  = 8'h02;
  localparam logic [7:0]  TYPE_VENDOR  = 8'h41;
  localparam int unsigned RANDOM_ITEMS = 760;
  localparam int unsigned LONG_ITEMS   = 770;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned DRAIN_CYCLES = 20;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push;
  logic [7:0]  data_byte_i;
  logic        last_byte_i;
  logic        full;
  logic        pop;
  logic        empty;
  logic [1:0]  record_kind_o;
  logic [1:0]  interface_number_o;
  logic [7:0]  interface_class_o;
  logic [7:0]  interface_subclass_o;
  logic [7:0]  interface_protocol_o;
  logic [1:0]  endpoint_slot_o;
  logic [6:0]  endpoint_address_o;
  logic        endpoint_is_in_o;
  logic [15:0] length_value_o;
  logic [2:0]  interface_count_o;
  logic [1:0]  walk_status_o;
  logic        last_record_o;

  usb_config_descriptor_walker u_dut (
    .clk_i, .rst_ni, .push, .data_byte_i, .last_byte_i, .full, .pop, .empty,
    .record_kind_o, .interface_number_o, .interface_class_o, .interface_subclass_o,
    .interface_protocol_o, .endpoint_slot_o, .endpoint_address_o, .endpoint_is_in_o,
    .length_value_o, .interface_count_o, .walk_status_o, .last_record_o
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state, one copy of the walker's registers
  logic [7:0]  desc_offset;
  logic [7:0]  desc_len;
  logic [7:0]  desc_kind;
  logic [15:0] stream_pos;
  logic [15:0] total_limit;
  logic [23:0] held;
  logic [1:0]  cur_if;
  logic        alt_zero;
  logic        if_seen;
  logic [2:0]  if_cap;
  logic [2:0]  ep_used [IF_SLOTS];
  stop_e       walk_stop;

  record_t     pending_records[$];
  logic [7:0]  set_buf[$];
  int unsigned fail_count = 0;
  int unsigned bytes_sent = 0;
  bit          sender_idles = 1'b0;
  bit          receiver_idles = 1'b0;

  function automatic logic [7:0] rand8();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic clear_walk();
    desc_offset = '0;
    desc_len    = '0;
    desc_kind   = '0;
    stream_pos  = '0;
    total_limit = '0;
    held        = '0;
    cur_if      = '0;
    alt_zero    = 1'b0;
    if_seen     = 1'b0;
    if_cap      = '0;
    foreach (ep_used[i]) ep_used[i] = '0;
    walk_stop   = STOP_RUN;
  endtask

  // one byte of the descriptor walk, may queue one record
  task automatic walk_step(input logic [7:0] b, input logic [15:0] pos);
    record_t     rec;
    int unsigned off;
    logic [2:0]  slot;
    off = desc_offset;
    rec = '0;
    rec.if_num = cur_if;
    if (off == 0) begin
      if (pos != 0 && pos >= total_limit) begin
        walk_stop = STOP_ENDED;
        return;
      end
      if (b == 8'h00) begin
        walk_stop = STOP_ZERO_LEN;
        return;
      end
      desc_len  = b;
      desc_kind = '0;
      held      = '0;
    end else if (off == 1) begin
      // the configuration type byte is never taken as a type
      if (pos != 1) desc_kind = b;
    end else if (desc_kind == TYPE_INTERFACE) begin
      if (off == 2) begin
        if (b >= 8'(if_cap)) begin
          walk_stop = STOP_BAD_IF;
          return;
        end
        cur_if  = b[1:0];
        if_seen = 1'b1;
      end else if (off == 3) begin
        alt_zero = (b == 8'h00);
        if (alt_zero) ep_used[cur_if] = '0;
      end else if (off == 5) begin
        held[7:0] = b;
      end else if (off == 6) begin
        held[15:8] = b;
      end else if (off == 7 && alt_zero) begin
        rec.kind        = REC_INTERFACE;
        rec.if_class    = held[7:0];
        rec.if_subclass = held[15:8];
        rec.if_protocol = b;
        pending_records.push_back(rec);
      end
    end else if (desc_kind == TYPE_HID) begin
      if (off == 6) begin
        held[7:0] = b;
      end else if (off == 7) begin
        held[15:8] = b;
      end else if (off == 8 && if_seen && held[7:0] == TYPE_REPORT) begin
        rec.kind   = REC_REPORT;
        rec.length = {b, held[15:8]};
        pending_records.push_back(rec);
      end
    end else if (desc_kind == TYPE_ENDPOINT) begin
      if (off == 2) begin
        // only endpoints of a base alternate setting with a free slot are kept
        if (if_seen && alt_zero && ep_used[cur_if] < EP_SLOTS) begin
          held = '0;
          held[ACCEPT_BIT] = 1'b1;
          held[7:0] = b;
        end
      end else if (off == 4) begin
        held[15:8] = b;
      end else if (off == 5 && held[ACCEPT_BIT]) begin
        slot        = ep_used[cur_if];
        rec.kind    = REC_ENDPOINT;
        rec.ep_slot = slot[1:0];
        rec.ep_addr = 7'(held[7:0] & ADDR_MASK);
        rec.ep_in   = |(held[7:0] & DIR_IN_BIT);
        rec.length  = {b, held[15:8]};
        pending_records.push_back(rec);
        ep_used[cur_if]  = slot + 3'd1;
        held[ACCEPT_BIT] = 1'b0;
      end
    end
    off = off + 1;
    desc_offset = (off >= desc_len) ? 8'd0 : 8'(off);
  endtask

  // expected records for one accepted request
  task automatic predict_records(input logic [7:0] b, input logic fin);
    record_t     rec;
    logic [15:0] pos;
    pos = stream_pos;
    // header fields always come from stream bytes 2 to 4
    if (pos == 16'd2) total_limit[7:0] = b;
    else if (pos == 16'd3) total_limit[15:8] = b;
    else if (pos == 16'd4) if_cap = (b > IF_SLOTS) ? 3'(IF_SLOTS) : b[2:0];
    if (walk_stop == STOP_RUN) walk_step(b, pos);
    if (pos != 16'hffff) stream_pos = pos + 16'd1;
    if (fin) begin
      rec          = '0;
      rec.kind     = REC_DONE;
      rec.if_count = if_cap;
      rec.status   = (walk_stop == STOP_BAD_IF)   ? STATUS_BAD_IF :
                     (walk_stop == STOP_ZERO_LEN) ? STATUS_ZERO_LEN : STATUS_OK;
      rec.last     = 1'b1;
      pending_records.push_back(rec);
      clear_walk();
    end
  endtask

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic check_record();
    record_t want;
    if (pending_records.size() == 0) begin
      $error("record of kind %0d arrived with none expected", record_kind_o);
      fail_count++;
      return;
    end
    want = pending_records.pop_front();
    check_field("record_kind", want.kind, record_kind_o);
    check_field("interface_number", want.if_num, interface_number_o);
    check_field("interface_class", want.if_class, interface_class_o);
    check_field("interface_subclass", want.if_subclass, interface_subclass_o);
    check_field("interface_protocol", want.if_protocol, interface_protocol_o);
    check_field("endpoint_slot", want.ep_slot, endpoint_slot_o);
    check_field("endpoint_address", want.ep_addr, endpoint_address_o);
    check_field("endpoint_is_in", want.ep_in, endpoint_is_in_o);
    check_field("length_value", want.length, length_value_o);
    check_field("interface_count", want.if_count, interface_count_o);
    check_field("walk_status", want.status, walk_status_o);
    check_field("last_record", want.last, last_record_o);
  endtask

  // send one request, predicting its records once it is taken
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    gap = sender_idles ? $urandom_range(0, 17) : 0;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push        <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= fin;
    do @(posedge clk_i); while (full);
    predict_records(b, fin);
    bytes_sent++;
  endtask

  task automatic send_set(input bit with_last);
    foreach (set_buf[i]) send_byte(set_buf[i], with_last && (i == set_buf.size() - 1));
  endtask

  // append one descriptor; lengths past the template are padded with random bytes
  task automatic add_desc(input int unsigned dlen, input logic [7:0] dtype,
                          input logic [7:0] f2, f3, f4, f5, f6, f7, f8);
    logic [7:0] body [9];
    body = '{8'(dlen), dtype, f2, f3, f4, f5, f6, f7, f8};
    if (dlen == 0) set_buf.push_back(8'h00);
    for (int unsigned i = 0; i < dlen; i++) set_buf.push_back((i < 9) ? body[i] : rand8());
  endtask

  function automatic int unsigned pick_len(input int unsigned full_len);
    return ($urandom_range(0, 7) != 0) ? full_len : $urandom_range(1, full_len + 3);
  endfunction

  // mostly well-formed configuration sets with random content and occasional damage
  task automatic build_config_set();
    int unsigned roll;
    int unsigned n_if;
    int unsigned hdr_len;
    int unsigned if_total;
    int unsigned n_ep;
    int unsigned total_len;
    logic [7:0]  if_id;
    logic [7:0]  alt;
    set_buf.delete();
    roll = $urandom_range(0, 9);
    n_if = (roll < 7) ? $urandom_range(1, 3) :
           (roll < 9) ? $urandom_range(0, 6) : $urandom_range(0, 255);
    hdr_len = ($urandom_range(0, 9) != 0) ? 9 : $urandom_range(0, 12);
    add_desc(hdr_len, TYPE_CONFIG, 8'h00, 8'h00, 8'(n_if), rand8(), rand8(), rand8(), rand8());
    // stray hid or endpoint ahead of any interface
    if ($urandom_range(0, 5) == 0)
      add_desc(9, $urandom_range(0, 1) ? TYPE_ENDPOINT : TYPE_HID, rand8(), rand8(), rand8(),
               rand8(), TYPE_REPORT, rand8(), rand8());
    if_total = (n_if > IF_SLOTS) ? IF_SLOTS : n_if;
    if ($urandom_range(0, 4) == 0) if_total++;
    for (int unsigned i = 0; i < if_total; i++) begin
      roll  = $urandom_range(0, 19);
      if_id = (roll == 0) ? rand8() : (roll < 3) ? 8'($urandom_range(0, 5)) : 8'(i);
      alt   = ($urandom_range(0, 4) != 0) ? 8'h00 : rand8();
      n_ep  = $urandom_range(0, 6);
      add_desc(pick_len(9), TYPE_INTERFACE, if_id, alt, 8'(n_ep), rand8(), rand8(), rand8(),
               rand8());
      if ($urandom_range(0, 1) != 0)
        add_desc(pick_len(9), TYPE_HID, rand8(), rand8(), rand8(), rand8(),
                 ($urandom_range(0, 7) != 0) ? TYPE_REPORT : rand8(), rand8(), rand8());
      repeat (n_ep)
        add_desc(pick_len(7), TYPE_ENDPOINT, rand8(), rand8(), rand8(), rand8(), rand8(),
                 rand8(), rand8());
      roll = $urandom_range(0, 24);
      if (roll == 0)
        add_desc(0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      else if (roll < 3)
        add_desc($urandom_range(1, 12), rand8(), rand8(), rand8(), rand8(), rand8(), rand8(),
                 rand8(), rand8());
    end
    // total length: mostly exact, sometimes short or long
    if (hdr_len >= 4) begin
      roll = $urandom_range(0, 9);
      total_len = (roll < 7) ? set_buf.size() :
                  (roll < 9) ? $urandom_range(0, set_buf.size()) :
                               $urandom_range(set_buf.size(), 65535);
      set_buf[2] = total_len[7:0];
      set_buf[3] = total_len[15:8];
    end
    // received bytes end before the set does
    if ($urandom_range(0, 9) == 0) begin
      total_len = $urandom_range(1, set_buf.size());
      while (set_buf.size() > total_len) void'(set_buf.pop_back());
    end
  endtask

  task automatic test_zero_length();
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    set_buf = '{8'h00};
    send_set(1'b1);
    set_buf = '{8'hff};
    send_set(1'b1);
  endtask

  // short configuration header; the interface number lands on the count byte
  task automatic test_header_overlap();
    set_buf.delete();
    add_desc(2, TYPE_CONFIG, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    add_desc(9, TYPE_INTERFACE, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_set(1'b1);
  endtask

  // a record of each kind, with two endpoint records, and extreme field values
  task automatic test_descriptor_records();
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    set_buf.delete();
    add_desc(5, TYPE_CONFIG, 8'd37, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00);
    add_desc(9, TYPE_INTERFACE, 8'h00, 8'h00, 8'h02, 8'h03, 8'h01, 8'h02, 8'h00);
    add_desc(9, TYPE_HID, 8'h11, 8'h01, 8'h00, 8'h01, TYPE_REPORT, 8'hff, 8'hff);
    add_desc(7, TYPE_ENDPOINT, 8'h81, 8'h03, 8'hff, 8'hff, 8'h01, 8'h00, 8'h00);
    add_desc(7, TYPE_ENDPOINT, 8'h7f, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_set(1'b1);
  endtask

  task automatic test_random_sets();
    int unsigned goal;
    goal = bytes_sent + RANDOM_ITEMS;
    while (bytes_sent < goal) begin
      sender_idles   = ($urandom_range(0, 3) != 0);
      receiver_idles = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) begin
        // raw noise, sometimes running on into the next set
        set_buf.delete();
        repeat ($urandom_range(1, 40)) set_buf.push_back(rand8());
        send_set($urandom_range(0, 4) != 0);
      end else begin
        build_config_set();
        send_set(1'b1);
      end
    end
  endtask

  // long vendor descriptors walked under the largest total length
  task automatic test_long_stream();
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    set_buf.delete();
    add_desc(9, TYPE_CONFIG, 8'hff, 8'hff, 8'h01, rand8(), rand8(), rand8(), rand8());
    while (set_buf.size() < LONG_ITEMS)
      add_desc(255, TYPE_VENDOR, rand8(), rand8(), rand8(), rand8(), rand8(), rand8(), rand8());
    send_set(1'b1);
  endtask

  // record side: random stalls, every returned record checked
  initial begin : record_sink
    int unsigned gap;
    pop <= 1'b0;
    wait (rst_ni);
    forever begin
      gap = receiver_idles ? $urandom_range(0, 17) : 0;
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      check_record();
    end
  end

  // watchdog on cycles with no request or record moving
  initial begin : stall_watchdog
    int unsigned stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (push && !full) || (pop && !empty)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("usb_config_descriptor_walker: mismatch");
    $finish;
  end

  // test sequence
  initial begin
    push        <= 1'b0;
    data_byte_i <= '0;
    last_byte_i <= 1'b0;
    clear_walk();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_zero_length();
    test_header_overlap();
    test_descriptor_records();
    test_random_sets();
    test_long_stream();
    push <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) $display("usb_config_descriptor_walker: match");
    else $display("usb_config_descriptor_walker: mismatch");
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/ucdw_pkg.sv
src/ucdw_fifo.sv
src/ucdw_front.sv
src/ucdw_walk.sv
src/ucdw_emit.sv
src/usb_config_descriptor_walker.sv
verif/tb.sv
